### rtl/core/dtk_pkg.sv
`default_nettype none

package dtk_pkg;

    typedef logic [1:0] op_t;

    localparam op_t OP_OFFER = 2'd0;
    localparam op_t OP_READ  = 2'd1;
    localparam op_t OP_CLEAR = 2'd2;
    localparam op_t OP_NONE  = 2'd3;

    localparam int         RANK_BITS    = 7;
    localparam int         LENGTH_BITS  = 8;
    localparam logic [7:0] LENGTH_RESET = 8'd10;

    // Control broadcast to every cell of one list
    typedef struct packed {
        logic shift;
        logic clear;
    } dtk_cmd_t;

endpackage

`default_nettype wire

### rtl/core/dtk_cell.sv
`default_nettype none

module dtk_cell #(
    parameter int COUNT_BITS = 32,
    parameter int ID_BITS    = 24
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  dtk_pkg::dtk_cmd_t     cmd,
    input  logic                  active,
    input  logic [COUNT_BITS-1:0] key,
    input  logic [ID_BITS-1:0]    key_id,
    input  logic                  gt_above,
    input  logic [COUNT_BITS-1:0] prev_count,
    input  logic [ID_BITS-1:0]    prev_id,
    output logic                  gt,
    output logic [COUNT_BITS-1:0] count,
    output logic [ID_BITS-1:0]    entry_id
);
    import dtk_pkg::*;

    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic [ID_BITS-1:0]    id_reg;
    logic [ID_BITS-1:0]    id_next;

    assign gt = key > count_reg;

    always_comb
    begin
        count_next = count_reg;
        id_next    = id_reg;
        if (cmd.clear)
        begin
            count_next = '0;
            id_next    = '0;
        end
        else if (cmd.shift && active)
        begin
            // the neighbor above moves down when the key lands above us
            if (gt_above)
            begin
                count_next = prev_count;
                id_next    = prev_id;
            end
            else if (gt)
            begin
                count_next = key;
                id_next    = key_id;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            id_reg    <= '0;
        end
        else
        begin
            count_reg <= count_next;
            id_reg    <= id_next;
        end
    end

    assign count    = count_reg;
    assign entry_id = id_reg;

endmodule

`default_nettype wire

### rtl/core/dtk_list.sv
`default_nettype none

module dtk_list #(
    parameter int MAX_RANKS  = 128,
    parameter int ID_BITS    = 24,
    parameter int COUNT_BITS = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          offer,
    input  logic                          clear,
    input  logic [MAX_RANKS-1:0]          active,
    input  logic [COUNT_BITS-1:0]         key,
    input  logic [ID_BITS-1:0]            key_id,
    input  logic [dtk_pkg::RANK_BITS-1:0] rank,
    output logic                          inserted,
    output logic [COUNT_BITS-1:0]         read_count,
    output logic [ID_BITS-1:0]            read_id
);
    import dtk_pkg::*;

    logic [COUNT_BITS-1:0] cell_count [MAX_RANKS];
    logic [ID_BITS-1:0]    cell_id    [MAX_RANKS];
    logic [MAX_RANKS-1:0]  cell_gt;
    logic [MAX_RANKS-1:0]  order_ok;
    logic [MAX_RANKS-1:0]  nonzero;
    logic                  fits;
    dtk_cmd_t              cmd;

    // Entries stay sorted, so the key fits iff it beats some active entry
    assign fits      = |(cell_gt & active);
    assign inserted  = offer && fits;
    assign cmd.shift = offer && fits;
    assign cmd.clear = clear;

    for (genvar k = 0; k < MAX_RANKS; k++)
    begin : g_cell
        logic                  gt_above;
        logic [COUNT_BITS-1:0] prev_count;
        logic [ID_BITS-1:0]    prev_id;

        if (k == 0)
        begin : g_head
            assign gt_above   = 1'b0;
            assign prev_count = '0;
            assign prev_id    = '0;
            assign order_ok[k] = 1'b1;
        end
        else
        begin : g_body
            assign gt_above   = cell_gt[k-1];
            assign prev_count = cell_count[k-1];
            assign prev_id    = cell_id[k-1];
            assign order_ok[k] = cell_count[k] <= cell_count[k-1];
        end

        assign nonzero[k] = |cell_count[k];

        dtk_cell #(
            .COUNT_BITS (COUNT_BITS),
            .ID_BITS    (ID_BITS)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (cmd),
            .active     (active[k]),
            .key        (key),
            .key_id     (key_id),
            .gt_above   (gt_above),
            .prev_count (prev_count),
            .prev_id    (prev_id),
            .gt         (cell_gt[k]),
            .count      (cell_count[k]),
            .entry_id   (cell_id[k])
        );
    end

    always_comb
    begin
        read_count = '0;
        read_id    = '0;
        for (int k = 0; k < MAX_RANKS; k++)
        begin
            if (32'(rank) == k)
            begin
                read_count = read_count | cell_count[k];
                read_id    = read_id | cell_id[k];
            end
        end
    end

    a_sorted: assert property (@(posedge clk) disable iff (!rst_n) &order_ok)
        else $error("rank cells out of descending order");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        clear |=> (nonzero == '0))
        else $error("clear left an entry behind");

endmodule

`default_nettype wire

### rtl/core/dual_top_k_ranker_top.sv
`default_nettype none

// Two descending top-K lists, one keyed by peer count and one by seed count,
// each a chain of MAX_RANKS cells that compare the offered key in parallel and
// shift lower entries down by one rank in the same cycle. Every beat on the
// input (offer, read, clear, no-op) produces exactly one output beat, which
// appears in the cycle after the input beat is taken; one beat per cycle is
// sustained while the output side does not stall, since the whole cell row
// updates together. A read at rank r selects cell r through a one-hot mux;
// list_length is written on the cfg channel (always ready) and not capped,
// but only MAX_RANKS ranks exist; write it only while the block is idle.
module dual_top_k_ranker_top #(
    parameter int MAX_RANKS  = 128,
    parameter int ID_BITS    = 24,
    parameter int COUNT_BITS = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            in_valid,
    output logic                            in_stall,
    input  dtk_pkg::op_t                    op,
    input  logic [ID_BITS-1:0]              item_id,
    input  logic [COUNT_BITS-1:0]           peer_total,
    input  logic [COUNT_BITS-1:0]           seed_total,
    input  logic [dtk_pkg::RANK_BITS-1:0]   rank,

    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            peer_inserted,
    output logic                            seed_inserted,
    output logic                            peer_entry_valid,
    output logic [COUNT_BITS-1:0]           peer_entry_count,
    output logic [ID_BITS-1:0]              peer_entry_id,
    output logic                            seed_entry_valid,
    output logic [COUNT_BITS-1:0]           seed_entry_count,
    output logic [ID_BITS-1:0]              seed_entry_id,

    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [dtk_pkg::LENGTH_BITS-1:0] cfg_data
);
    import dtk_pkg::*;

    logic [LENGTH_BITS-1:0] list_length_reg;
    logic                   out_valid_reg;
    logic                   peer_inserted_reg;
    logic                   seed_inserted_reg;
    logic                   peer_valid_reg;
    logic [COUNT_BITS-1:0]  peer_cnt_reg;
    logic [ID_BITS-1:0]     peer_id_reg;
    logic                   seed_valid_reg;
    logic [COUNT_BITS-1:0]  seed_cnt_reg;
    logic [ID_BITS-1:0]     seed_id_reg;

    logic                   peer_inserted_next;
    logic                   seed_inserted_next;
    logic                   peer_valid_next;
    logic [COUNT_BITS-1:0]  peer_cnt_next;
    logic [ID_BITS-1:0]     peer_id_next;
    logic                   seed_valid_next;
    logic [COUNT_BITS-1:0]  seed_cnt_next;
    logic [ID_BITS-1:0]     seed_id_next;

    logic                   load;
    logic                   do_offer;
    logic                   do_clear;
    logic                   rank_ok;
    logic [MAX_RANKS-1:0]   active;
    logic                   peer_hit;
    logic                   seed_hit;
    logic [COUNT_BITS-1:0]  peer_rd_count;
    logic [ID_BITS-1:0]     peer_rd_id;
    logic [COUNT_BITS-1:0]  seed_rd_count;
    logic [ID_BITS-1:0]     seed_rd_id;

    // hold input while an unread result sits in the output register
    assign in_stall  = out_valid_reg && out_stall;
    assign load      = in_valid && !in_stall;
    assign do_offer  = load && (op == OP_OFFER);
    assign do_clear  = load && (op == OP_CLEAR);
    assign cfg_ready = 1'b1;

    for (genvar k = 0; k < MAX_RANKS; k++)
    begin : g_active
        assign active[k] = 32'(list_length_reg) > k;
    end

    assign rank_ok = (32'(rank) < 32'(list_length_reg)) && (32'(rank) < MAX_RANKS);

    dtk_list #(
        .MAX_RANKS  (MAX_RANKS),
        .ID_BITS    (ID_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_peer (
        .clk        (clk),
        .rst_n      (rst_n),
        .offer      (do_offer),
        .clear      (do_clear),
        .active     (active),
        .key        (peer_total),
        .key_id     (item_id),
        .rank       (rank),
        .inserted   (peer_hit),
        .read_count (peer_rd_count),
        .read_id    (peer_rd_id)
    );

    dtk_list #(
        .MAX_RANKS  (MAX_RANKS),
        .ID_BITS    (ID_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_seed (
        .clk        (clk),
        .rst_n      (rst_n),
        .offer      (do_offer),
        .clear      (do_clear),
        .active     (active),
        .key        (seed_total),
        .key_id     (item_id),
        .rank       (rank),
        .inserted   (seed_hit),
        .read_count (seed_rd_count),
        .read_id    (seed_rd_id)
    );

    always_comb
    begin
        peer_inserted_next = 1'b0;
        seed_inserted_next = 1'b0;
        peer_valid_next    = 1'b0;
        peer_cnt_next      = '0;
        peer_id_next       = '0;
        seed_valid_next    = 1'b0;
        seed_cnt_next      = '0;
        seed_id_next       = '0;
        unique case (op) inside
            OP_OFFER:
            begin
                peer_inserted_next = peer_hit;
                seed_inserted_next = seed_hit;
            end
            OP_READ:
            begin
                if (rank_ok)
                begin
                    peer_valid_next = |peer_rd_count;
                    peer_cnt_next   = peer_rd_count;
                    peer_id_next    = peer_rd_id;
                    seed_valid_next = |seed_rd_count;
                    seed_cnt_next   = seed_rd_count;
                    seed_id_next    = seed_rd_id;
                end
            end
            OP_CLEAR, OP_NONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            list_length_reg <= LENGTH_RESET;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                list_length_reg <= cfg_data;
            end
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            peer_inserted_reg <= peer_inserted_next;
            seed_inserted_reg <= seed_inserted_next;
            peer_valid_reg    <= peer_valid_next;
            peer_cnt_reg      <= peer_cnt_next;
            peer_id_reg       <= peer_id_next;
            seed_valid_reg    <= seed_valid_next;
            seed_cnt_reg      <= seed_cnt_next;
            seed_id_reg       <= seed_id_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign peer_inserted    = peer_inserted_reg;
    assign seed_inserted    = seed_inserted_reg;
    assign peer_entry_valid = peer_valid_reg;
    assign peer_entry_count = peer_cnt_reg;
    assign peer_entry_id    = peer_id_reg;
    assign seed_entry_valid = seed_valid_reg;
    assign seed_entry_count = seed_cnt_reg;
    assign seed_entry_id    = seed_id_reg;

    a_every_beat_answers: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> out_valid_reg)
        else $error("accepted beat produced no result");

    a_zero_peer_stays_out: assert property (@(posedge clk) disable iff (!rst_n)
        (do_offer && (peer_total == '0)) |=> !peer_inserted_reg)
        else $error("zero peer count entered the list");

    a_read_no_insert: assert property (@(posedge clk) disable iff (!rst_n)
        (load && (op == OP_READ)) |=> (!peer_inserted_reg && !seed_inserted_reg))
        else $error("read reported an insertion");

endmodule

`default_nettype wire
